>>> rtl/sdf_pkg.sv
// shared types and constants for the primitive distance pipeline
package sdf_pkg;

  localparam int CW   = 32;        // coordinate width
  localparam int FB   = 16;        // fraction bits
  localparam int MW   = CW + 1;    // magnitude of a coordinate difference
  localparam int RW   = CW + 2;    // square root width
  localparam int SW   = 2 * RW;    // radicand width
  localparam int RMW  = RW + 3;    // square root remainder width
  localparam int IW   = 3;         // config index width
  localparam int OW   = 32;        // distance width

  localparam logic [CW-2:0] SIZE_RESET = (CW-1)'(1) << FB;

  typedef enum logic [1:0] {
    KIND_SPHERE = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_CYL    = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [IW-1:0] {
    REG_KIND     = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_CENTER_Z = 3'd3,
    REG_SIZE_A   = 3'd4,
    REG_SIZE_B   = 3'd5,
    REG_SIZE_C   = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic [CW-2:0]      a;
    logic signed [RW:0] d1;
    logic signed [RW:0] d0;
    logic [RW-1:0]      root1;
  } sdf_side_t;

  typedef struct packed {
    logic           valid;
    logic [SW-1:0]  s;
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    sdf_side_t      side;
  } sdf_sq_t;

endpackage

>>> rtl/sdf_if.sv
// handshake channel interfaces for points, distances and config writes
interface sdf_point_if;
  import sdf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sdf_dist_if;
  import sdf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] distance;
  logic                 saturated;
  modport source (output valid, distance, saturated, input ready);
  modport sink (input valid, distance, saturated, output ready);
endinterface

interface sdf_cfg_if;
  import sdf_pkg::*;
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [CW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/sdf_sqrt_cell.sv
// one digit step of the integer square root, two radicand bits per cell
module sdf_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  sdf_pkg::sdf_sq_t din,
  output sdf_pkg::sdf_sq_t dout
);
  import sdf_pkg::*;

  logic [RMW-1:0] remx;
  logic [RMW-1:0] trial;
  logic           take;

  assign remx  = {din.rem[RMW-3:0], din.s[SW-1 -: 2]};
  assign trial = {1'b0, din.root, 2'b01};
  assign take  = remx >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
      dout.s     <= {din.s[SW-3:0], 2'b00};
      dout.rem   <= take ? remx - trial : remx;
      dout.root  <= {din.root[RW-2:0], take};
      dout.side  <= din.side;
    end
  end
endmodule

>>> rtl/sdf_sqrt_chain.sv
// row of square root cells, one root bit resolved per stage
module sdf_sqrt_chain (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  sdf_pkg::sdf_sq_t din,
  output sdf_pkg::sdf_sq_t dout
);
  import sdf_pkg::*;

  sdf_sq_t stage [0:RW];

  assign stage[0] = din;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    sdf_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign dout = stage[RW];
endmodule

>>> rtl/sdf_primitive_distance.sv
// distance from a query point to one configured sphere, box or capped cylinder
//
//  channel | dir | content
//  --------+-----+-------------------------------------------
//  cfg     | in  | register index and write data
//  query   | in  | point_x, point_y, point_z
//  result  | out | distance, saturated
//
// fully pipelined: one point per cycle while result is not stalled; the stages
// include the two square root cell rows (one root bit per cell)
// rst is synchronous and clears all stage valid bits and the config registers
// a stalled result freezes the whole pipeline; query.ready is high while result is empty or result.ready is high
module sdf_primitive_distance (
  input logic          clk,
  input logic          rst,
  sdf_cfg_if.sink      cfg,
  sdf_point_if.sink    query,
  sdf_dist_if.source   result
);
  import sdf_pkg::*;

  kind_t         shape_kind;
  logic [CW-1:0] center_x, center_y, center_z;
  logic [CW-2:0] size_a, size_b, size_c;

  logic en;
  assign en          = !result.valid || result.ready;
  assign query.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind <= KIND_SPHERE;
      center_x   <= '0;
      center_y   <= '0;
      center_z   <= '0;
      size_a     <= SIZE_RESET;
      size_b     <= SIZE_RESET;
      size_c     <= SIZE_RESET;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_KIND:     shape_kind <= kind_t'(cfg.data[1:0]);
        REG_CENTER_X: center_x   <= cfg.data;
        REG_CENTER_Y: center_y   <= cfg.data;
        REG_CENTER_Z: center_z   <= cfg.data;
        REG_SIZE_A:   size_a     <= cfg.data[CW-2:0];
        REG_SIZE_B:   size_b     <= cfg.data[CW-2:0];
        REG_SIZE_C:   size_c     <= cfg.data[CW-2:0];
        default:      ;
      endcase
    end
  end

  // stage 1: coordinate difference magnitudes
  logic signed [CW:0] dx, dy, dz;
  logic [MW-1:0] ax, ay, az;
  logic          v1;
  assign dx = {query.point_x[CW-1], query.point_x} - {center_x[CW-1], center_x};
  assign dy = {query.point_y[CW-1], query.point_y} - {center_y[CW-1], center_y};
  assign dz = {query.point_z[CW-1], query.point_z} - {center_z[CW-1], center_z};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= query.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax <= dx[CW] ? MW'(-dx) : MW'(dx);
      ay <= dy[CW] ? MW'(-dy) : MW'(dy);
      az <= dz[CW] ? MW'(-dz) : MW'(dz);
    end
  end

  // stage 2: operands of the first length
  logic [MW-1:0] o0, o1, o2;
  logic [MW-1:0] ea, eb, ec;
  sdf_side_t     side2;
  logic          v2;
  assign ea = {2'b00, size_a};
  assign eb = {2'b00, size_b};
  assign ec = {2'b00, size_c};

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      case (shape_kind)
        KIND_BOX: begin
          o0 <= (ax > ea) ? ax - ea : '0;
          o1 <= (ay > eb) ? ay - eb : '0;
          o2 <= (az > ec) ? az - ec : '0;
        end
        KIND_CYL: begin
          o0 <= ax;
          o1 <= az;
          o2 <= '0;
        end
        default: begin
          o0 <= ax;
          o1 <= ay;
          o2 <= az;
        end
      endcase
      side2.kind  <= shape_kind;
      side2.a     <= size_a;
      side2.d1    <= $signed({2'b00, ay}) - $signed({4'b0000, size_b});
      side2.d0    <= '0;
      side2.root1 <= '0;
    end
  end

  // stage 3: squares
  logic [2*MW-1:0] p0, p1, p2;
  sdf_side_t       side3;
  logic            v3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p0    <= {{MW{1'b0}}, o0} * {{MW{1'b0}}, o0};
      p1    <= {{MW{1'b0}}, o1} * {{MW{1'b0}}, o1};
      p2    <= {{MW{1'b0}}, o2} * {{MW{1'b0}}, o2};
      side3 <= side2;
    end
  end

  // stage 4: sum of squares into the first root row
  sdf_sq_t ca_in, ca_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      ca_in.valid <= 1'b0;
    end else if (en) begin
      ca_in.valid <= v3;
      ca_in.s     <= {2'b00, p0} + {2'b00, p1} + {2'b00, p2};
      ca_in.rem   <= '0;
      ca_in.root  <= '0;
      ca_in.side  <= side3;
    end
  end

  sdf_sqrt_chain u_len1 (
    .clk (clk), .rst (rst), .en (en), .din (ca_in), .dout (ca_out)
  );

  // stage 5: cylinder radial and height offsets
  logic signed [RW:0] d0;
  logic [RW-1:0]      q0, q1;
  sdf_side_t          side5;
  logic               v5;
  assign d0 = $signed({1'b0, ca_out.root}) - $signed({4'b0000, ca_out.side.a});

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= ca_out.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q0    <= d0[RW] ? '0 : d0[RW-1:0];
      q1    <= ca_out.side.d1[RW] ? '0 : ca_out.side.d1[RW-1:0];
      side5 <= '{kind: ca_out.side.kind, a: ca_out.side.a, d1: ca_out.side.d1,
                 d0: d0, root1: ca_out.root};
    end
  end

  // stage 6: squares of the clamped offsets
  logic [SW-1:0] r0, r1;
  sdf_side_t     side6;
  logic          v6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r0    <= {{RW{1'b0}}, q0} * {{RW{1'b0}}, q0};
      r1    <= {{RW{1'b0}}, q1} * {{RW{1'b0}}, q1};
      side6 <= side5;
    end
  end

  // stage 7: into the second root row
  sdf_sq_t cb_in, cb_out;
  logic [SW:0] rsum;
  assign rsum = {1'b0, r0} + {1'b0, r1};
  always_ff @(posedge clk) begin
    if (rst) begin
      cb_in.valid <= 1'b0;
    end else if (en) begin
      cb_in.valid <= v6;
      cb_in.s     <= rsum[SW-1:0];
      cb_in.rem   <= '0;
      cb_in.root  <= '0;
      cb_in.side  <= side6;
    end
  end

  sdf_sqrt_chain u_len2 (
    .clk (clk), .rst (rst), .en (en), .din (cb_in), .dout (cb_out)
  );

  // final: select by shape and saturate
  logic signed [RW:0]   mx, inner;
  logic signed [RW+2:0] res;
  logic                 hi, lo;
  assign mx    = (cb_out.side.d0 > cb_out.side.d1) ? cb_out.side.d0 : cb_out.side.d1;
  assign inner = mx[RW] ? mx : '0;

  always_comb begin
    case (cb_out.side.kind)
      KIND_BOX: res = $signed({3'b000, cb_out.side.root1});
      KIND_CYL: res = {{2{inner[RW]}}, inner} + $signed({3'b000, cb_out.root});
      default:  res = {{2{cb_out.side.d0[RW]}}, cb_out.side.d0};
    endcase
  end
  assign hi = res > $signed((RW+3)'({1'b0, {(OW-1){1'b1}}}));
  assign lo = res < -$signed((RW+3)'({1'b1, {(OW-1){1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= cb_out.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      result.saturated <= hi || lo;
      if (hi) result.distance <= {1'b0, {(OW-1){1'b1}}};
      else if (lo) result.distance <= {1'b1, {(OW-1){1'b0}}};
      else result.distance <= res[OW-1:0];
    end
  end
endmodule

>>> rtl/sdf_checker.sv
// port-level checks for the primitive distance block, bound to the top level
module sdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        q_ready,
  input logic        r_valid,
  input logic        r_ready,
  input logic [31:0] r_distance,
  input logic        r_saturated
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_distance) && $stable(r_saturated))
    else $error("result changed while stalled");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    q_ready == (!r_valid || r_ready))
    else $error("query ready does not follow result space");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_saturated |-> r_distance == 32'h7fffffff || r_distance == 32'h80000000)
    else $error("saturated result is not a limit value");

  a_reset_empty: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");
endmodule

bind sdf_primitive_distance sdf_checker u_sdf_checker (
  .clk         (clk),
  .rst         (rst),
  .q_ready     (query.ready),
  .r_valid     (result.valid),
  .r_ready     (result.ready),
  .r_distance  (result.distance),
  .r_saturated (result.saturated)
);
